/* rtl/sc1a_pkg.sv */
`default_nettype none

package sc1a_pkg;

	localparam logic [7:0] CODE_PREFIX      = 8'hE0;
	localparam logic [7:0] CODE_SHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] CODE_SHIFT_BREAK = 8'hAA;
	localparam logic [7:0] CODE_LEFT        = 8'h4B;
	localparam logic [7:0] CODE_RIGHT       = 8'h4D;
	localparam logic [7:0] CODE_BACKSPACE   = 8'h0E;
	localparam logic [7:0] CODE_NONE        = 8'h00;

	localparam logic [7:0] CHAR_NONE  = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_POUND = 8'hA3;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;

	typedef enum logic [1:0] {
		CUR_NONE  = 2'd0,
		CUR_LEFT  = 2'd1,
		CUR_RIGHT = 2'd2
	} cursor_move_t;

	typedef struct packed {
		logic         char_valid;
		logic [7:0]   char_code;
		cursor_move_t cursor_move;
	} result_t;

	function automatic logic [7:0] char_lookup(input logic [7:0] code, input logic shifted);
		logic [7:0] ch;
		ch = CHAR_NONE;
		case (code)
			8'h02: ch = shifted ? "!" : "1";
			8'h03: ch = shifted ? CHAR_QUOTE : "2";
			8'h04: ch = shifted ? CHAR_POUND : "3";
			8'h05: ch = shifted ? "$" : "4";
			8'h06: ch = shifted ? "%" : "5";
			8'h07: ch = shifted ? "^" : "6";
			8'h08: ch = shifted ? "&" : "7";
			8'h09: ch = shifted ? "*" : "8";
			8'h0A: ch = shifted ? "(" : "9";
			8'h0B: ch = shifted ? ")" : "0";
			8'h10: ch = shifted ? "Q" : "q";
			8'h11: ch = shifted ? "W" : "w";
			8'h12: ch = shifted ? "E" : "e";
			8'h13: ch = shifted ? "R" : "r";
			8'h14: ch = shifted ? "T" : "t";
			8'h15: ch = shifted ? "Y" : "y";
			8'h16: ch = shifted ? "U" : "u";
			8'h17: ch = shifted ? "I" : "i";
			8'h18: ch = shifted ? "O" : "o";
			8'h19: ch = shifted ? "P" : "p";
			8'h1A: ch = shifted ? "{" : "[";
			8'h1B: ch = shifted ? "}" : "]";
			8'h1C: ch = CHAR_LF;
			8'h1E: ch = shifted ? "A" : "a";
			8'h1F: ch = shifted ? "S" : "s";
			8'h20: ch = shifted ? "D" : "d";
			8'h21: ch = shifted ? "F" : "f";
			8'h22: ch = shifted ? "G" : "g";
			8'h23: ch = shifted ? "H" : "h";
			8'h24: ch = shifted ? "J" : "j";
			8'h25: ch = shifted ? "K" : "k";
			8'h26: ch = shifted ? "L" : "l";
			8'h2C: ch = shifted ? "Z" : "z";
			8'h2D: ch = shifted ? "X" : "x";
			8'h2E: ch = shifted ? "C" : "c";
			8'h2F: ch = shifted ? "V" : "v";
			8'h30: ch = shifted ? "B" : "b";
			8'h31: ch = shifted ? "N" : "n";
			8'h32: ch = shifted ? "M" : "m";
			8'h39: ch = " ";
			default: ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

/* rtl/sc1a_code_if.sv */
`default_nettype none

interface sc1a_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_code;

	modport source (output valid, output scan_code, input ready);
	modport sink (input valid, input scan_code, output ready);
endinterface

`default_nettype wire

/* rtl/sc1a_char_if.sv */
`default_nettype none

interface sc1a_char_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [7:0] char_code;
	logic [1:0] cursor_move;

	modport source (output valid, output char_valid, output char_code, output cursor_move,
		input ready);
	modport sink (input valid, input char_valid, input char_code, input cursor_move,
		output ready);
endinterface

`default_nettype wire

/* rtl/scan_code_set1_to_ascii_top.sv */
`default_nettype none

// Set 1 scan code to character translator, UK layout, left shift only. Each scan code
// transaction on codes gives exactly one transaction on chars, and a new code is taken
// every cycle while chars does not stall: one input register, one table lookup against
// the shift and extended-prefix flags, one result register. Prefix 0xE0 arms the
// extended flag; the next nonzero code but 0xE0 clears it and reports cursor left (0x4B)
// or right (0x4D). Otherwise 0x2A/0xAA set and clear shift, 0x0E gives backspace, code
// zero changes nothing, and unmapped codes give char_valid 0, char_code 0, cursor_move 0.
module scan_code_set1_to_ascii_top (
	input  wire         clk,
	input  wire         arst_n,
	sc1a_code_if.sink   codes,
	sc1a_char_if.source chars
);

	logic              valid_s1;
	logic [7:0]        code_s1;
	logic              valid_s2;
	sc1a_pkg::result_t result_s2;
	logic              shift_q;
	logic              ext_q;

	logic              adv_s1;
	logic              adv_s2;
	logic              shift_d;
	logic              ext_d;
	sc1a_pkg::result_t result_d;

	assign adv_s2       = !valid_s2 || chars.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign codes.ready  = adv_s1;

	assign chars.valid       = valid_s2;
	assign chars.char_valid  = result_s2.char_valid;
	assign chars.char_code   = result_s2.char_code;
	assign chars.cursor_move = result_s2.cursor_move;

	always_comb begin
		shift_d              = shift_q;
		ext_d                = ext_q;
		result_d.char_code   = sc1a_pkg::CHAR_NONE;
		result_d.cursor_move = sc1a_pkg::CUR_NONE;
		if (code_s1 == sc1a_pkg::CODE_NONE) begin
			ext_d = ext_q;
		end else if (code_s1 == sc1a_pkg::CODE_PREFIX) begin
			ext_d = 1'b1;
		end else if (ext_q) begin
			ext_d = 1'b0;
			if (code_s1 == sc1a_pkg::CODE_LEFT) begin
				result_d.cursor_move = sc1a_pkg::CUR_LEFT;
			end else if (code_s1 == sc1a_pkg::CODE_RIGHT) begin
				result_d.cursor_move = sc1a_pkg::CUR_RIGHT;
			end
		end else if (code_s1 == sc1a_pkg::CODE_BACKSPACE) begin
			result_d.char_code = sc1a_pkg::CODE_BACKSPACE;
		end else if (code_s1 == sc1a_pkg::CODE_SHIFT_MAKE) begin
			shift_d = 1'b1;
		end else if (code_s1 == sc1a_pkg::CODE_SHIFT_BREAK) begin
			shift_d = 1'b0;
		end else begin
			result_d.char_code = sc1a_pkg::char_lookup(code_s1, shift_q);
		end
		result_d.char_valid = (result_d.char_code != sc1a_pkg::CHAR_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			shift_q  <= 1'b0;
			ext_q    <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= codes.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			// advance flags only when the stage 1 transaction moves on
			if (valid_s1 && adv_s2) begin
				shift_q <= shift_d;
				ext_q   <= ext_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			code_s1 <= codes.scan_code;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

`ifndef SYNTHESIS
	a_char_valid_code : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.char_valid == (result_s2.char_code != sc1a_pkg::CHAR_NONE)))
		else $error("char_valid disagrees with char_code");

	a_move_no_char : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (result_s2.cursor_move != sc1a_pkg::CUR_NONE)) |-> !result_s2.char_valid)
		else $error("cursor move together with a character");

	a_prefix_arms : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && (code_s1 == sc1a_pkg::CODE_PREFIX)) |=> ext_q)
		else $error("prefix did not arm extended flag");

	a_move_needs_prefix : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && (result_d.cursor_move != sc1a_pkg::CUR_NONE)) |-> ext_q)
		else $error("cursor move without pending prefix");
`endif

endmodule

`default_nettype wire

/* tb/scan_code_set1_to_ascii_top_tb.sv */
`timescale 1ns / 100ps

module scan_code_set1_to_ascii_top_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 100;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [8*10-1:0] DIGIT_PLAIN = "1234567890";
	localparam logic [8*10-1:0] DIGIT_SHIFT = {"!", sc1a_pkg::CHAR_QUOTE, sc1a_pkg::CHAR_POUND,
		"$%^&*()"};
	localparam logic [8*12-1:0] TOP_PLAIN   = "qwertyuiop[]";
	localparam logic [8*12-1:0] TOP_SHIFT   = "QWERTYUIOP{}";
	localparam logic [8*9-1:0]  HOME_PLAIN  = "asdfghjkl";
	localparam logic [8*9-1:0]  HOME_SHIFT  = "ASDFGHJKL";
	localparam logic [8*7-1:0]  LOW_PLAIN   = "zxcvbnm";
	localparam logic [8*7-1:0]  LOW_SHIFT   = "ZXCVBNM";

	logic clk = 1'b0;
	logic arst_n;

	sc1a_code_if codes();
	sc1a_char_if chars();

	scan_code_set1_to_ascii_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.codes  (codes),
		.chars  (chars)
	);

	logic              shift_held = 1'b0;
	logic              prefix_pending = 1'b0;
	sc1a_pkg::result_t expected_chars[$];
	int                mismatch_count = 0;
	int                cycle_count = 0;
	int                codes_sent;
	int                sender_idle_pct;
	int                sink_stall_pct;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] key_char(input logic [7:0] code, input logic shifted);
		logic [7:0] ch;
		int         idx;
		ch = sc1a_pkg::CHAR_NONE;
		if (code >= 8'h02 && code <= 8'h0B) begin
			idx = code - 8'h02;
			ch = shifted ? DIGIT_SHIFT[8*(9-idx) +: 8] : DIGIT_PLAIN[8*(9-idx) +: 8];
		end else if (code >= 8'h10 && code <= 8'h1B) begin
			idx = code - 8'h10;
			ch = shifted ? TOP_SHIFT[8*(11-idx) +: 8] : TOP_PLAIN[8*(11-idx) +: 8];
		end else if (code == 8'h1C) begin
			ch = sc1a_pkg::CHAR_LF;
		end else if (code >= 8'h1E && code <= 8'h26) begin
			idx = code - 8'h1E;
			ch = shifted ? HOME_SHIFT[8*(8-idx) +: 8] : HOME_PLAIN[8*(8-idx) +: 8];
		end else if (code >= 8'h2C && code <= 8'h32) begin
			idx = code - 8'h2C;
			ch = shifted ? LOW_SHIFT[8*(6-idx) +: 8] : LOW_PLAIN[8*(6-idx) +: 8];
		end else if (code == 8'h39) begin
			ch = " ";
		end
		return ch;
	endfunction

	function automatic sc1a_pkg::result_t translate_code(input logic [7:0] code);
		sc1a_pkg::result_t      res;
		logic [7:0]             ch;
		sc1a_pkg::cursor_move_t mv;
		ch = sc1a_pkg::CHAR_NONE;
		mv = sc1a_pkg::CUR_NONE;
		if (code == sc1a_pkg::CODE_NONE) begin
			ch = sc1a_pkg::CHAR_NONE;
		end else if (code == sc1a_pkg::CODE_PREFIX) begin
			prefix_pending = 1'b1;
		end else if (prefix_pending) begin
			prefix_pending = 1'b0;
			if (code == sc1a_pkg::CODE_LEFT)
				mv = sc1a_pkg::CUR_LEFT;
			else if (code == sc1a_pkg::CODE_RIGHT)
				mv = sc1a_pkg::CUR_RIGHT;
		end else if (code == sc1a_pkg::CODE_BACKSPACE) begin
			ch = sc1a_pkg::CODE_BACKSPACE;
		end else if (code == sc1a_pkg::CODE_SHIFT_MAKE) begin
			shift_held = 1'b1;
		end else if (code == sc1a_pkg::CODE_SHIFT_BREAK) begin
			shift_held = 1'b0;
		end else begin
			ch = key_char(code, shift_held);
		end
		res.char_valid  = (ch != sc1a_pkg::CHAR_NONE);
		res.char_code   = ch;
		res.cursor_move = mv;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// predict on each accepted code, check each accepted result
	always @(posedge clk) begin
		sc1a_pkg::result_t exp_char;
		if (arst_n && codes.valid && codes.ready)
			expected_chars.push_back(translate_code(codes.scan_code));
		if (arst_n && chars.valid && chars.ready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected result char_code=%h", chars.char_code));
			end else begin
				exp_char = expected_chars.pop_front();
				if (chars.char_valid !== exp_char.char_valid)
					report_mismatch($sformatf("char_valid exp %b got %b",
						exp_char.char_valid, chars.char_valid));
				if (chars.char_code !== exp_char.char_code)
					report_mismatch($sformatf("char_code exp %h got %h",
						exp_char.char_code, chars.char_code));
				if (chars.cursor_move !== exp_char.cursor_move)
					report_mismatch($sformatf("cursor_move exp %0d got %0d",
						exp_char.cursor_move, chars.cursor_move));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(negedge clk)
		chars.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

	// enter and leave on a falling edge
	task automatic send_code(input logic [7:0] code);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			codes.valid <= 1'b0;
			@(negedge clk);
		end
		codes.valid     <= 1'b1;
		codes.scan_code <= code;
		do
			@(posedge clk);
		while (!codes.ready);
		@(negedge clk);
		codes_sent++;
	endtask

	task automatic test_code_extremes();
		send_code(8'h00);
		send_code(8'hFF);
		send_code(8'h01);
		send_code(8'h80);
		send_code(8'h3A);
		send_code(8'h39);
	endtask

	task automatic test_shift_keys();
		send_code(sc1a_pkg::CODE_SHIFT_MAKE);
		send_code(8'h04);
		send_code(8'h03);
		send_code(8'h1C);
		send_code(8'h10);
		send_code(sc1a_pkg::CODE_SHIFT_BREAK);
		send_code(8'h04);
	endtask

	task automatic test_backspace();
		send_code(sc1a_pkg::CODE_BACKSPACE);
	endtask

	task automatic test_extended_keys();
		send_code(sc1a_pkg::CODE_PREFIX);
		send_code(sc1a_pkg::CODE_LEFT);
		send_code(sc1a_pkg::CODE_PREFIX);
		send_code(sc1a_pkg::CODE_PREFIX);
		send_code(sc1a_pkg::CODE_RIGHT);
		send_code(sc1a_pkg::CODE_PREFIX);
		send_code(sc1a_pkg::CODE_NONE);
		send_code(sc1a_pkg::CODE_LEFT);
		send_code(sc1a_pkg::CODE_PREFIX);
		send_code(sc1a_pkg::CODE_SHIFT_MAKE);
		send_code(8'h1E);
		send_code(sc1a_pkg::CODE_SHIFT_MAKE);
		send_code(sc1a_pkg::CODE_PREFIX);
		send_code(sc1a_pkg::CODE_SHIFT_BREAK);
		send_code(8'h1E);
		send_code(sc1a_pkg::CODE_SHIFT_BREAK);
	endtask

	task automatic send_random_keystroke();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_code(8'($urandom_range(1, 8'h39)));
		end else if (pick < 50) begin
			send_code($urandom_range(0, 1) ? sc1a_pkg::CODE_SHIFT_MAKE
				: sc1a_pkg::CODE_SHIFT_BREAK);
		end else if (pick < 65) begin
			send_code(sc1a_pkg::CODE_PREFIX);
			if ($urandom_range(0, 7) == 0)
				send_code($urandom_range(0, 1) ? sc1a_pkg::CODE_PREFIX : sc1a_pkg::CODE_NONE);
			case ($urandom_range(0, 3))
				0: send_code(sc1a_pkg::CODE_LEFT);
				1: send_code(sc1a_pkg::CODE_RIGHT);
				2: send_code($urandom_range(0, 1) ? sc1a_pkg::CODE_SHIFT_MAKE
					: sc1a_pkg::CODE_SHIFT_BREAK);
				default: send_code(8'($urandom_range(0, 255)));
			endcase
		end else if (pick < 70) begin
			send_code(sc1a_pkg::CODE_BACKSPACE);
		end else if (pick < 75) begin
			send_code(sc1a_pkg::CODE_NONE);
		end else begin
			send_code(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int stop_at;
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		stop_at = codes_sent + RANDOM_ITEMS;
		while (codes_sent < stop_at)
			send_random_keystroke();
	endtask

	initial begin
		arst_n          = 1'b0;
		codes.valid     = 1'b0;
		codes.scan_code = sc1a_pkg::CODE_NONE;
		codes_sent      = 0;
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_code_extremes();
		test_shift_keys();
		test_backspace();
		test_extended_keys();
		test_random_traffic(0, 0);
		test_random_traffic(72, 0);
		test_random_traffic(0, 72);
		test_random_traffic(30, 30);

		codes.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
